[src/ppvc_pkg.sv]
// Shared types and constants for the planar PD velocity command block.
// Holds register indexes, fixed widths and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package ppvc_pkg;

    localparam int unsigned REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_GAIN_POS_X   = 3'd0;
    localparam reg_idx_t REG_GAIN_POS_Y   = 3'd1;
    localparam reg_idx_t REG_GAIN_VEL_X   = 3'd2;
    localparam reg_idx_t REG_GAIN_VEL_Y   = 3'd3;
    localparam reg_idx_t REG_GAIN_HEADING = 3'd4;

    // yaw vector width: Q.28 operands plus CORDIC growth
    localparam int unsigned CORDIC_W   = 38;
    localparam int unsigned ATAN_LEN   = 24;
    // integer square root of a 49-bit sum gives 25 bits
    localparam int unsigned ROOT_W     = 25;
    localparam int unsigned RAD_W      = 2 * ROOT_W;

    localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;

    localparam logic [31:0] ATAN_TURN32 [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage
`default_nettype wire

[src/planar_pd_velocity_command.sv]
// Planar PD velocity command: top level, complete pipelined datapath.
// Depends on ppvc_pkg.
`default_nettype none
// Takes one pose sample per cycle while the output is not stalled and returns
// one command per sample, in order. Two front stages form the
// products and the PD/atan2 operands, then the speed branch (squares, sum, one
// square-root bit per stage over 25 stages, rounding) and the yaw branch
// (quadrant fold, one CORDIC micro-rotation per stage, error, two multiplies,
// rounding) run side by side and are aligned at the output. The whole pipe
// advances whenever the output register is empty or being taken, so a new
// transaction is accepted every cycle the result side keeps up. The user must
// write gains via the plain write port while the pipe is empty; not enforced.
module planar_pd_velocity_command #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [ppvc_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                  cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [15:0]           s_target_x,
    input  wire logic signed [15:0]           s_target_y,
    input  wire logic [15:0]                  s_target_heading,
    input  wire logic signed [15:0]           s_meas_x,
    input  wire logic signed [15:0]           s_meas_y,
    input  wire logic signed [15:0]           s_meas_vx,
    input  wire logic signed [15:0]           s_meas_vy,
    input  wire logic signed [15:0]           s_orient_qx,
    input  wire logic signed [15:0]           s_orient_qy,
    input  wire logic signed [15:0]           s_orient_qz,
    input  wire logic signed [15:0]           s_orient_qw,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [15:0]                       m_linear_speed,
    output logic signed [15:0]                m_turn_rate
);
    import ppvc_pkg::*;

    localparam int unsigned N      = CORDIC_STAGES;
    localparam int unsigned L_SPD  = ROOT_W + 2;
    localparam int unsigned L_YAW  = N + 4;
    localparam int unsigned L      = ((L_SPD > L_YAW) ? L_SPD : L_YAW) + 1;
    localparam int unsigned DS     = L - L_SPD;
    localparam int unsigned DY     = L - L_YAW;
    localparam int unsigned LAT    = L + 2;

    // configuration
    logic [15:0] gain_pos_x_reg, gain_pos_y_reg, gain_vel_x_reg, gain_vel_y_reg;
    logic [15:0] gain_heading_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_pos_x_reg   <= 16'd256;
            gain_pos_y_reg   <= 16'd256;
            gain_vel_x_reg   <= 16'd0;
            gain_vel_y_reg   <= 16'd0;
            gain_heading_reg <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_POS_X:   gain_pos_x_reg   <= cfg_wdata;
                REG_GAIN_POS_Y:   gain_pos_y_reg   <= cfg_wdata;
                REG_GAIN_VEL_X:   gain_vel_x_reg   <= cfg_wdata;
                REG_GAIN_VEL_Y:   gain_vel_y_reg   <= cfg_wdata;
                REG_GAIN_HEADING: gain_heading_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage A: products
    logic signed [16:0] dx, dy;
    logic signed [33:0] px_reg, py_reg, vxp_reg, vyp_reg;
    logic signed [31:0] qwz_reg, qxy_reg, qyy_reg, qzz_reg;
    logic [15:0]        th_a_reg;

    assign dx = 17'(s_target_x) - 17'(s_meas_x);
    assign dy = 17'(s_target_y) - 17'(s_meas_y);

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg   <= $signed({1'b0, gain_pos_x_reg}) * dx;
            py_reg   <= $signed({1'b0, gain_pos_y_reg}) * dy;
            vxp_reg  <= $signed({1'b0, gain_vel_x_reg}) * s_meas_vx;
            vyp_reg  <= $signed({1'b0, gain_vel_y_reg}) * s_meas_vy;
            qwz_reg  <= s_orient_qw * s_orient_qz;
            qxy_reg  <= s_orient_qx * s_orient_qy;
            qyy_reg  <= s_orient_qy * s_orient_qy;
            qzz_reg  <= s_orient_qz * s_orient_qz;
            th_a_reg <= s_target_heading;
        end
    end

    // stage B: PD terms and atan2 operands
    logic signed [33:0] ux_reg, uy_reg, num_reg, den_reg;
    logic signed [33:0] num_next, den_next;
    logic [15:0]        th_b_reg;

    assign num_next = (34'(qwz_reg) + 34'(qxy_reg)) <<< 1;
    assign den_next = 34'sd268435456 - ((34'(qyy_reg) + 34'(qzz_reg)) <<< 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ux_reg   <= px_reg - vxp_reg;
            uy_reg   <= py_reg - vyp_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
            th_b_reg <= th_a_reg;
        end
    end

    // speed branch: magnitudes and squares
    logic [33:0]       ax, ay;
    logic [47:0]       sqx_reg, sqy_reg;
    logic              sat_sq_reg;

    assign ax = ux_reg[33] ? 34'(-ux_reg) : 34'(ux_reg);
    assign ay = uy_reg[33] ? 34'(-uy_reg) : 34'(uy_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg    <= 48'(ax[23:0]) * 48'(ax[23:0]);
            sqy_reg    <= 48'(ay[23:0]) * 48'(ay[23:0]);
            sat_sq_reg <= (ax[33:24] != '0) || (ay[33:24] != '0);
        end
    end

    // square root, one result bit per stage; index 0 is the sum stage
    logic [RAD_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic              satr_reg [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            root_reg[0] <= '0;
            satr_reg[0] <= sat_sq_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        localparam int unsigned B = ROOT_W - 1 - k;
        logic [RAD_W-1:0] trial;
        assign trial = (RAD_W'(root_reg[k]) << (B + 1)) | (RAD_W'(1) << (2 * B));
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= root_reg[k] | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
                satr_reg[k+1] <= satr_reg[k];
            end
        end
    end

    logic [ROOT_W:0] spd_rnd;
    logic [15:0]     spd_fin;

    assign spd_rnd = {1'b0, root_reg[ROOT_W]} + (ROOT_W + 1)'(128);
    assign spd_fin = (satr_reg[ROOT_W] || (spd_rnd[ROOT_W:24] != '0))
                     ? 16'hFFFF : spd_rnd[23:8];

    logic [15:0] spd_dly_reg [0:DS-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            spd_dly_reg[0] <= spd_fin;
        end
    end
    for (genvar d = 1; d < DS; d++) begin : g_spd_dly
        always_ff @(posedge aclk) begin
            if (adv) begin
                spd_dly_reg[d] <= spd_dly_reg[d-1];
            end
        end
    end

    // yaw branch: fold into the right half plane; index 0 is that stage
    logic signed [CORDIC_W-1:0] cx_reg  [0:N];
    logic signed [CORDIC_W-1:0] cy_reg  [0:N];
    logic [31:0]                cz_reg  [0:N];
    logic                       deg_reg [0:N];
    logic [15:0]                cth_reg [0:N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_reg[0] <= (num_reg == '0) && (den_reg == '0);
            cth_reg[0] <= th_b_reg;
            if (den_reg[33]) begin
                if (!num_reg[33]) begin
                    cx_reg[0] <= CORDIC_W'(num_reg);
                    cy_reg[0] <= -CORDIC_W'(den_reg);
                    cz_reg[0] <= 32'h40000000;
                end else begin
                    cx_reg[0] <= -CORDIC_W'(num_reg);
                    cy_reg[0] <= CORDIC_W'(den_reg);
                    cz_reg[0] <= 32'hC0000000;
                end
            end else begin
                cx_reg[0] <= CORDIC_W'(den_reg);
                cy_reg[0] <= CORDIC_W'(num_reg);
                cz_reg[0] <= 32'h0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CORDIC_W-1:0] xs, ys;
        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (cy_reg[i] > 0) begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_TURN32[i];
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_TURN32[i];
                end
                deg_reg[i+1] <= deg_reg[i];
                cth_reg[i+1] <= cth_reg[i];
            end
        end
    end

    // heading error, then gain, then radians scale
    logic [31:0]        z_rnd;
    logic [15:0]        yaw;
    logic signed [15:0] err_reg;
    logic signed [32:0] gerr_reg;
    logic signed [63:0] prod_reg;

    assign z_rnd = cz_reg[N] + 32'h8000;
    assign yaw   = deg_reg[N] ? 16'h0 : z_rnd[31:16];

    always_ff @(posedge aclk) begin
        if (adv) begin
            err_reg  <= $signed(cth_reg[N] - yaw);
            gerr_reg <= $signed({1'b0, gain_heading_reg}) * err_reg;
            prod_reg <= 64'(gerr_reg) * 64'(TWO_PI_Q28);
        end
    end

    logic signed [63:0] tr_sum;
    logic signed [19:0] tr_full;
    logic signed [15:0] tr_fin;

    assign tr_sum  = prod_reg + 64'sd8796093022208;
    assign tr_full = tr_sum[63:44];

    always_comb begin
        if (tr_full > 20'sd32767) begin
            tr_fin = 16'sh7FFF;
        end else if (tr_full < -20'sd32768) begin
            tr_fin = 16'sh8000;
        end else begin
            tr_fin = tr_full[15:0];
        end
    end

    logic signed [15:0] tr_dly_reg [0:DY-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            tr_dly_reg[0] <= tr_fin;
        end
    end
    for (genvar d = 1; d < DY; d++) begin : g_tr_dly
        always_ff @(posedge aclk) begin
            if (adv) begin
                tr_dly_reg[d] <= tr_dly_reg[d-1];
            end
        end
    end

    assign m_linear_speed = spd_dly_reg[DS-1];
    assign m_turn_rate    = tr_dly_reg[DY-1];

endmodule
`default_nettype wire
